/* rtl/gcs_pkg.sv */
// ---------------------------------------------------------------------------
// gcs_pkg: shared types and constants for the gray contrast stretch block
// Pixel width, register indexes, queue entry layout and back-end states.
// ---------------------------------------------------------------------------
package gcs_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int PROD_BITS  = 2 * PIXEL_BITS;
  localparam int CNT_BITS   = $clog2(PIXEL_BITS);
  localparam int CFG_IDX_BITS = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_MAX = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_MIN = CFG_IDX_BITS'(1);

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_REMAP   = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // One remap item, already classified by the front end.
  typedef struct packed {
    logic pass;   // flat/empty measured range or inverted target range
    pix_t pixel;  // original pixel, used on pass
    pix_t diff;   // clamped pixel minus seen_min
    pix_t trange; // target_max - target_min
    pix_t den;    // seen_max - seen_min
    pix_t tmin;   // target_min
  } gcs_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } gcs_back_state_t;

endpackage

/* rtl/gcs_if.sv */
// ---------------------------------------------------------------------------
// gcs_if: channel interfaces for the gray contrast stretch block
// Pixel input, result output and configuration write channels.
// ---------------------------------------------------------------------------
interface gcs_in_if;
  logic                 valid;
  logic                 ready;
  logic                 op;
  gcs_pkg::pix_t        pixel;
  logic                 first;

  modport source (output valid, op, pixel, first, input ready);
  modport sink   (input valid, op, pixel, first, output ready);
endinterface

interface gcs_out_if;
  logic                 valid;
  logic                 ready;
  gcs_pkg::pix_t        pixel_out;
  logic                 passed_through;

  modport source (output valid, pixel_out, passed_through, input ready);
  modport sink   (input valid, pixel_out, passed_through, output ready);
endinterface

interface gcs_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [gcs_pkg::CFG_IDX_BITS-1:0]     index;
  gcs_pkg::pix_t                        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/gcs_queue.sv */
// ---------------------------------------------------------------------------
// gcs_queue: short FIFO between front and back
// Holds classified remap items so each side can stall on its own.
// ---------------------------------------------------------------------------
module gcs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gcs_pkg::gcs_entry_t push_data,
  input  logic                pop,
  output gcs_pkg::gcs_entry_t pop_data,
  output logic                full,
  output logic                empty
);

  gcs_pkg::gcs_entry_t               slots [gcs_pkg::QUEUE_DEPTH];
  logic [gcs_pkg::QPTR_BITS-1:0]     wr_ptr;
  logic [gcs_pkg::QPTR_BITS-1:0]     rd_ptr;
  logic [gcs_pkg::QPTR_BITS:0]       fill;

  assign full     = (fill == (gcs_pkg::QPTR_BITS+1)'(gcs_pkg::QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/gcs_front.sv */
// ---------------------------------------------------------------------------
// gcs_front: input side of the contrast stretch
// Holds target range and running min/max, folds measure items, classifies
// remap items and pushes them to the queue.
// ---------------------------------------------------------------------------
module gcs_front (
  input  logic                clk,
  input  logic                rst,
  gcs_in_if.sink              pix_in,
  gcs_cfg_if.sink             cfg,
  input  logic                q_full,
  output logic                q_push,
  output gcs_pkg::gcs_entry_t q_data
);

  gcs_pkg::pix_t target_max;
  gcs_pkg::pix_t target_min;
  gcs_pkg::pix_t seen_max;
  gcs_pkg::pix_t seen_min;
  gcs_pkg::pix_t clamped;
  logic          accept;

  assign pix_in.ready = !q_full;
  assign cfg.ready    = 1'b1;
  assign accept       = pix_in.valid && pix_in.ready;
  assign q_push       = accept && (pix_in.op == gcs_pkg::OP_REMAP);

  always_comb begin
    clamped = pix_in.pixel;
    if (clamped < seen_min) begin
      clamped = seen_min;
    end
    if (clamped > seen_max) begin
      clamped = seen_max;
    end
    q_data.pass   = (seen_max <= seen_min) || (target_min > target_max);
    q_data.pixel  = pix_in.pixel;
    q_data.diff   = clamped - seen_min;
    q_data.trange = target_max - target_min;
    q_data.den    = seen_max - seen_min;
    q_data.tmin   = target_min;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_max <= '1;
      target_min <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        gcs_pkg::CFG_TARGET_MAX: target_max <= cfg.data;
        gcs_pkg::CFG_TARGET_MIN: target_min <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_max <= '0;
      seen_min <= '1;
    end else if (accept && (pix_in.op == gcs_pkg::OP_MEASURE)) begin
      if (pix_in.first) begin
        seen_max <= pix_in.pixel;
        seen_min <= pix_in.pixel;
      end else begin
        if (pix_in.pixel > seen_max) begin
          seen_max <= pix_in.pixel;
        end
        if (pix_in.pixel < seen_min) begin
          seen_min <= pix_in.pixel;
        end
      end
    end
  end

endmodule

/* rtl/gcs_back.sv */
// ---------------------------------------------------------------------------
// gcs_back: remap engine
// A multiply step, then a restoring divider one quotient bit a cycle;
// the result sits in the output register until taken.
// ---------------------------------------------------------------------------
module gcs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  gcs_pkg::gcs_entry_t q_data,
  output logic                q_pop,
  gcs_out_if.source           pix_out
);

  gcs_pkg::gcs_back_state_t          state;
  gcs_pkg::gcs_back_state_t          state_next;
  gcs_pkg::gcs_entry_t               job;
  logic [gcs_pkg::PROD_BITS-1:0]     prod;
  gcs_pkg::pix_t                     rem;
  gcs_pkg::pix_t                     quo;
  gcs_pkg::pix_t                     quo_next;
  logic [gcs_pkg::PIXEL_BITS:0]      trial;
  logic                              take;
  logic [gcs_pkg::CNT_BITS-1:0]      step;
  logic                              last_step;
  gcs_pkg::pix_t                     result;
  logic                              result_pass;

  assign prod      = gcs_pkg::PROD_BITS'(job.diff) * gcs_pkg::PROD_BITS'(job.trange);
  assign trial     = {rem, quo[gcs_pkg::PIXEL_BITS-1]};
  assign take      = (trial >= {1'b0, job.den});
  assign quo_next  = {quo[gcs_pkg::PIXEL_BITS-2:0], take};
  assign last_step = (step == gcs_pkg::CNT_BITS'(gcs_pkg::PIXEL_BITS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gcs_pkg::BK_IDLE: if (!q_empty) state_next = q_data.pass ? gcs_pkg::BK_OUT
                                                               : gcs_pkg::BK_MUL;
      gcs_pkg::BK_MUL:  state_next = gcs_pkg::BK_DIV;
      gcs_pkg::BK_DIV:  if (last_step) state_next = gcs_pkg::BK_OUT;
      gcs_pkg::BK_OUT:  if (pix_out.ready) state_next = gcs_pkg::BK_IDLE;
      default:          state_next = gcs_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop         = 1'b0;
    pix_out.valid = 1'b0;
    unique case (state)
      gcs_pkg::BK_IDLE: q_pop = !q_empty;
      gcs_pkg::BK_OUT:  pix_out.valid = 1'b1;
      default: ;
    endcase
  end

  assign pix_out.pixel_out      = result;
  assign pix_out.passed_through = result_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcs_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      gcs_pkg::BK_IDLE: begin
        job         <= q_data;
        result      <= q_data.pixel;
        result_pass <= 1'b1;
      end
      gcs_pkg::BK_MUL: begin
        // quotient fits PIXEL_BITS, so the high half is already below den
        rem  <= prod[gcs_pkg::PROD_BITS-1:gcs_pkg::PIXEL_BITS];
        quo  <= prod[gcs_pkg::PIXEL_BITS-1:0];
        step <= '0;
      end
      gcs_pkg::BK_DIV: begin
        rem  <= take ? gcs_pkg::PIXEL_BITS'(trial - {1'b0, job.den})
                     : trial[gcs_pkg::PIXEL_BITS-1:0];
        quo  <= quo_next;
        step <= step + 1'b1;
        if (last_step) begin
          result      <= job.tmin + quo_next;
          result_pass <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/gray_contrast_stretch.sv */
// ---------------------------------------------------------------------------
// gray_contrast_stretch: min-max contrast stretch of gray pixels
// Measure items track the running min/max; remap items are stretched from
// the measured range onto the target range set by two config registers.
// ---------------------------------------------------------------------------
//
//  channel  | role  | payload                          | accepted when
//  ---------+-------+----------------------------------+----------------------
//  pix_in   | sink  | op, pixel, first                 | valid && ready
//  pix_out  | src   | pixel_out, passed_through        | valid && ready
//  cfg      | sink  | index (0 target_max, 1 target_min), data | valid && ready
//
//  Measure items are taken every cycle while the queue has room. A remap item
//  walks the states pop, multiply, one divide step per quotient bit and the
//  output hold; a passed-through item goes from pop to the output hold. The
//  serial divider sets the remap rate. Reset (rst, synchronous) clears min/max
//  to empty, target to full range, and empties the queue. A stalled output
//  holds the back end; the 4-entry queue lets the front take items until full.
//
module gray_contrast_stretch (
  input  logic       clk,
  input  logic       rst,
  gcs_in_if.sink     pix_in,
  gcs_out_if.source  pix_out,
  gcs_cfg_if.sink    cfg
);

  gcs_pkg::gcs_entry_t push_data;
  gcs_pkg::gcs_entry_t pop_data;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;

  // front: config, min/max tracking, classification of remap items
  gcs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix_in),
    .cfg    (cfg),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  // decoupling queue
  gcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // back: multiply, serial divide, output register
  gcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (empty),
    .q_data  (pop_data),
    .q_pop   (pop),
    .pix_out (pix_out)
  );

endmodule

/* verif/gcs_checker.sv */
// ---------------------------------------------------------------------------
// gcs_checker: scoreboard for the gray contrast stretch block
// Watches the pixel, result and register channels, keeps its own min/max
// and target range, predicts each remap result and compares it in order.
// ---------------------------------------------------------------------------
module gcs_checker (
  input  logic clk,
  input  logic rst,
  gcs_in_if    pix_in,
  gcs_out_if   pix_out,
  gcs_cfg_if   cfg,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   flagged_seen
);
  import gcs_pkg::*;

  typedef struct packed {
    pix_t pixel_out;
    logic passed_through;
  } stretched_t;

  pix_t       seen_max;
  pix_t       seen_min;
  pix_t       tgt_max;
  pix_t       tgt_min;
  stretched_t stretched_q[$];

  // Linear map of one pixel from the measured range onto the target range.
  function automatic stretched_t stretch_pixel(pix_t px);
    stretched_t               r;
    pix_t                     clamped;
    logic [PROD_BITS-1:0]     prod;
    logic [PROD_BITS-1:0]     quot;
    r.pixel_out      = px;
    r.passed_through = 1'b1;
    if (seen_max <= seen_min || tgt_min > tgt_max) begin
      return r;
    end
    clamped = px;
    if (clamped < seen_min) clamped = seen_min;
    if (clamped > seen_max) clamped = seen_max;
    prod = PROD_BITS'(clamped - seen_min) * PROD_BITS'(tgt_max - tgt_min);
    quot = prod / PROD_BITS'(seen_max - seen_min);
    r.pixel_out      = pix_t'(PROD_BITS'(tgt_min) + quot);
    r.passed_through = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    stretched_t want;
    if (rst) begin
      seen_max     = '0;
      seen_min     = '1;
      tgt_max      = '1;
      tgt_min      = '0;
      stretched_q.delete();
      fail_count   = 0;
      results_seen = 0;
      flagged_seen = 0;
    end else begin
      // results first: an item taken this cycle cannot already be out
      if (pix_out.valid && pix_out.ready) begin
        results_seen++;
        if (pix_out.passed_through) flagged_seen++;
        if (stretched_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result pixel_out %0d passed_through %0b, none expected",
                   $time, pix_out.pixel_out, pix_out.passed_through);
        end else begin
          want = stretched_q.pop_front();
          if (pix_out.pixel_out !== want.pixel_out) begin
            fail_count++;
            $display("%0t: pixel_out mismatch, expected %0d actual %0d",
                     $time, want.pixel_out, pix_out.pixel_out);
          end
          if (pix_out.passed_through !== want.passed_through) begin
            fail_count++;
            $display("%0t: passed_through mismatch, expected %0b actual %0b",
                     $time, want.passed_through, pix_out.passed_through);
          end
        end
      end
      if (pix_in.valid && pix_in.ready) begin
        if (pix_in.op == OP_REMAP) begin
          stretched_q.push_back(stretch_pixel(pix_in.pixel));
        end else if (pix_in.first) begin
          seen_min = pix_in.pixel;
          seen_max = pix_in.pixel;
        end else begin
          if (pix_in.pixel > seen_max) seen_max = pix_in.pixel;
          if (pix_in.pixel < seen_min) seen_min = pix_in.pixel;
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_TARGET_MAX: tgt_max = cfg.data;
          CFG_TARGET_MIN: tgt_min = cfg.data;
          default: ;
        endcase
      end
    end
    pending = stretched_q.size();
  end

endmodule

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the gray contrast stretch block
// Directed corner items, then random measure/remap frames under changing
// target ranges with random stalls on both sides; gcs_checker predicts and
// compares every result.
// ---------------------------------------------------------------------------
module tb_top;
  import gcs_pkg::*;

  localparam int HALF_PERIOD      = 6;
  localparam int RESET_CYCLES     = 9;
  // worst case drain of a full queue: each remap walks the serial divider
  localparam int SETTLE_CYCLES    = QUEUE_DEPTH * (PIXEL_BITS + 4) + 16;
  localparam int TOTAL_ITEMS      = 1950;
  localparam int CALM_ITEMS       = 250;   // tail of the run with no idling
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int LIMIT_CYCLES     = 400000;

  // register indexes past the defined list; writes to them must be ignored
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = CFG_IDX_BITS'(3);

  logic clk = 1'b0;
  logic rst;

  gcs_in_if  pix_in ();
  gcs_out_if pix_out ();
  gcs_cfg_if cfg ();

  int fail_count;
  int pending;
  int results_seen;
  int flagged_seen;

  bit gaps_on;        // random idling allowed on both sides
  bit hold_request;   // asks the result side for one long stall
  int items_sent;
  int measures_sent;
  int reg_writes;

  gray_contrast_stretch u_top (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  gcs_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .pix_in       (pix_in),
    .pix_out      (pix_out),
    .cfg          (cfg),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .flagged_seen (flagged_seen)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("timeout after %0d cycles, %0d results still due", LIMIT_CYCLES, pending);
    $display("tb_top NOT OK");
    $finish;
  end

  // Result side: short random stalls, plus one long hold on request so the
  // queue fills and the block has to back-pressure its input.
  initial begin
    int stall_left;
    stall_left    = 0;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        pix_out.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);   // burst of stall, length drawn at random
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // One pixel item. Called at a rising edge; returns at the edge that took
  // it, with valid still high so back-to-back items run without a gap.
  // ready is looked at on the falling edge, where it is settled.
  task automatic send_pixel(input logic op, input pix_t px, input logic frst);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.op    <= op;
    pix_in.pixel <= px;
    pix_in.first <= frst;
    do @(negedge clk); while (!pix_in.ready);
    @(posedge clk);
    items_sent++;
    if (op == OP_MEASURE) measures_sent++;
  endtask

  // Stop offering pixels and wait until every due result has come back,
  // then give the back end time to finish anything still in flight.
  task automatic settle();
    pix_in.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg.valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input pix_t val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(negedge clk); while (!cfg.ready);
    @(posedge clk);
    reg_writes++;
  endtask

  // New target range, written only once the block is idle.
  task automatic set_targets(input pix_t tmax, input pix_t tmin, input bit spare);
    settle();
    if (spare) begin
      write_reg(CFG_SPARE_A, pix_t'($urandom));
      write_reg(CFG_SPARE_B, pix_t'($urandom));
    end
    write_reg(CFG_TARGET_MAX, tmax);
    write_reg(CFG_TARGET_MIN, tmin);
    cfg.valid <= 1'b0;
  endtask

  // A random pick of target range, extremes weighted in.
  task automatic random_targets();
    pix_t a;
    pix_t b;
    a = pix_t'($urandom);
    b = pix_t'($urandom);
    case ($urandom_range(0, 5))
      0: set_targets(8'd255, 8'd0, $urandom_range(0, 2) == 0);   // full range
      1: set_targets(8'd0, 8'd255, 1'b0);                        // inverted
      2: set_targets(a, a, 1'b0);                                // zero width
      3: set_targets((a > b) ? a : b, (a > b) ? b : a, 1'b0);    // ordered
      4: set_targets(a, b, $urandom_range(0, 2) == 0);           // anything
      default: set_targets(8'd255, 8'd255, 1'b0);
    endcase
  endtask

  // One frame: a measure pass opened by first, then a remap pass. Most
  // frames are well formed; a few skip first (min/max carry over), and half
  // of those also remap before measuring. Narrow ranges stress the divider.
  task automatic run_frame();
    int lo;
    int hi;
    int span;
    int n_meas;
    int n_remap;
    int k;
    bit broken;
    case ($urandom_range(0, 3))
      0: span = 255;
      1: span = $urandom_range(0, 3);
      2: span = $urandom_range(4, 40);
      default: span = $urandom_range(0, 255);
    endcase
    lo      = $urandom_range(0, 255 - span);
    hi      = lo + span;
    n_meas  = $urandom_range(1, 8);
    n_remap = $urandom_range(1, 10);
    broken  = ($urandom_range(0, 9) == 0);
    if (broken && $urandom_range(0, 1) == 0) begin
      send_pixel(OP_REMAP, pix_t'($urandom), 1'($urandom));
    end
    for (k = 0; k < n_meas; k++) begin
      send_pixel(OP_MEASURE, pix_t'($urandom_range(hi, lo)),
                 (k == 0) ? !broken : ($urandom_range(0, 15) == 0));
    end
    for (k = 0; k < n_remap; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        // anywhere, so pixels outside the measured range get clamped
        send_pixel(OP_REMAP, pix_t'($urandom), 1'($urandom));
      end else begin
        send_pixel(OP_REMAP, pix_t'($urandom_range(hi, lo)), 1'($urandom));
      end
    end
  endtask

  initial begin
    int frame_no;
    int k;
    rst           = 1'b1;
    gaps_on       = 1'b0;
    hold_request  = 1'b0;
    items_sent    = 0;
    measures_sent = 0;
    reg_writes    = 0;
    pix_in.valid  <= 1'b0;
    pix_in.op     <= OP_MEASURE;
    pix_in.pixel  <= '0;
    pix_in.first  <= 1'b0;
    cfg.valid     <= 1'b0;
    cfg.index     <= CFG_TARGET_MAX;
    cfg.data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part, reset targets 0..255 ---
    // nothing measured yet: empty range, pass through; first on remap ignored
    send_pixel(OP_REMAP,   8'd0,   1'b0);
    send_pixel(OP_REMAP,   8'd255, 1'b1);
    // single measured value: flat range
    send_pixel(OP_MEASURE, 8'd100, 1'b1);
    send_pixel(OP_REMAP,   8'd100, 1'b0);
    // widen to the full 0..255 range: identity map
    send_pixel(OP_MEASURE, 8'd0,   1'b0);
    send_pixel(OP_MEASURE, 8'd255, 1'b0);
    send_pixel(OP_REMAP,   8'd0,   1'b0);
    send_pixel(OP_REMAP,   8'd255, 1'b0);
    send_pixel(OP_REMAP,   8'd128, 1'b0);
    // restart on 50..200, then clamp below and above
    send_pixel(OP_MEASURE, 8'd50,  1'b1);
    send_pixel(OP_MEASURE, 8'd200, 1'b0);
    send_pixel(OP_REMAP,   8'd10,  1'b0);
    send_pixel(OP_REMAP,   8'd250, 1'b0);
    send_pixel(OP_REMAP,   8'd125, 1'b0);
    // range of one step at the top
    send_pixel(OP_MEASURE, 8'd254, 1'b1);
    send_pixel(OP_MEASURE, 8'd255, 1'b0);
    send_pixel(OP_REMAP,   8'd254, 1'b0);
    // inverted target range, plus writes to the unused indexes
    set_targets(8'd0, 8'd255, 1'b1);
    send_pixel(OP_REMAP,   8'd255, 1'b0);
    send_pixel(OP_REMAP,   8'd0,   1'b0);
    // zero-width target: everything lands on target_min
    set_targets(8'd128, 8'd128, 1'b0);
    send_pixel(OP_REMAP,   8'd254, 1'b0);
    send_pixel(OP_REMAP,   8'd255, 1'b0);
    set_targets(8'd255, 8'd0, 1'b0);

    // --- random frames ---
    frame_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= TOTAL_ITEMS - CALM_ITEMS) begin
        gaps_on = 1'b0;
      end else begin
        gaps_on = ($urandom_range(0, 3) != 0);   // some frames run flat out
        if (frame_no % 12 == 11) random_targets();
      end
      if (frame_no == 20) begin
        // long output hold while the sender keeps going: queue fills up
        hold_request = 1'b1;
        for (k = 0; k < 24; k++) send_pixel(OP_REMAP, pix_t'($urandom), 1'b0);
      end
      if (frame_no == 40) settle();   // sender pause until all results are back
      run_frame();
      frame_no++;
    end

    pix_in.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("ran %0d pixel items (%0d measure) over %0d frames and %0d register writes",
             items_sent, measures_sent, frame_no, reg_writes);
    $display("checked %0d results, %0d of them passed through unchanged",
             results_seen, flagged_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
